>>> hdl/pgac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_pkg
// Types, constants and rounding helpers shared by the guidance command block.
// ----------------------------------------------------------------------------
package pgac_pkg;

  localparam int unsigned NUM_W = 38;  // ldot dividend width and divider step count
  localparam logic [29:0] LDOT_SCALE = 30'd4000000;
  localparam logic [15:0] GAIN_RESET = 16'd5120;

  localparam int unsigned SH_CROSS = 14;
  localparam int unsigned SH_GAIN  = 8;
  localparam int unsigned SH_ROT   = 4;
  localparam int unsigned SH_OUT   = 24;

  typedef enum logic [2:0] {
    SA_LD, SA_OM, SA_C, SA_ACCEL, SA_QUAT, SA_DMAG
  } asrc_e;

  typedef enum logic [2:0] {
    SB_LOS, SB_GAIN, SB_ROT, SB_QUAT, SB_SCALE
  } bsrc_e;

  typedef enum logic [1:0] {
    ACC_SET, ACC_ADD, ACC_SUB
  } accm_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_OM, DST_C, DST_ACCEL, DST_PROD, DST_RES
  } dst_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_OPND, CMD_MUL, CMD_ACC, CMD_WR,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_LD_SAT, CMD_OUT
  } cmd_e;

  typedef struct packed {
    asrc_e       asrc;
    logic [3:0]  aidx;
    bsrc_e       bsrc;
    logic [3:0]  bidx;
    accm_e       accm;
    dst_e        dst;
    logic [3:0]  didx;
  } uop_t;

  typedef struct packed {
    cmd_e        cmd;
    uop_t        uop;
    logic [1:0]  idx;
  } ctl_t;

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/pn_guidance_accel_command.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_guidance_accel_command
// Proportional navigation: body-frame lateral acceleration command per tick.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | los_x/y/z, att_w/x/y/z, dt_us
//  out     | out_valid_o/out_stall_i | acc_x/y/z, saturated
//  cfg     | cfg_we_i                | cfg_wdata_i (nav gain, Q8.8)
//
// one beat at a time; the first tick after reset skips the ldot path
// the ldot path runs three 38-step radix-2 divisions (one per component),
// then 34 multiplies on one shared 37x30 multiplier plus writes
// reset: nav gain 5120, previous los zero, next tick treated as first
// a finished result waits in the output register; a new beat is taken meanwhile
// ----------------------------------------------------------------------------
module pn_guidance_accel_command
  import pgac_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               cfg_we_i,
  input  wire  logic        [15:0] cfg_wdata_i,
  input  wire  logic               in_valid_i,
  output logic                     in_stall_o,
  input  wire  logic signed [15:0] los_x_i,
  input  wire  logic signed [15:0] los_y_i,
  input  wire  logic signed [15:0] los_z_i,
  input  wire  logic signed [15:0] att_w_i,
  input  wire  logic signed [15:0] att_x_i,
  input  wire  logic signed [15:0] att_y_i,
  input  wire  logic signed [15:0] att_z_i,
  input  wire  logic        [19:0] dt_us_i,
  output logic                     out_valid_o,
  input  wire  logic               out_stall_i,
  output logic signed [31:0]       acc_x_o,
  output logic signed [31:0]       acc_y_o,
  output logic signed [31:0]       acc_z_o,
  output logic                     saturated_o
);

  ctl_t ctl;

  pgac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  pgac_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .los_x_i     (los_x_i),
    .los_y_i     (los_y_i),
    .los_z_i     (los_z_i),
    .att_w_i     (att_w_i),
    .att_x_i     (att_x_i),
    .att_y_i     (att_y_i),
    .att_z_i     (att_z_i),
    .dt_us_i     (dt_us_i),
    .acc_x_o     (acc_x_o),
    .acc_y_o     (acc_y_o),
    .acc_z_o     (acc_z_o),
    .saturated_o (saturated_o)
  );

endmodule
`default_nettype wire

>>> hdl/pgac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_ctrl
// Sequencer: runs the ldot divisions and the fixed multiply program.
// ----------------------------------------------------------------------------
module pgac_ctrl
  import pgac_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  output ctl_t       ctl_o
);

  localparam logic [5:0] LAST_STEP = 6'd33;

  typedef enum logic [3:0] {
    S_IDLE, S_OPND, S_MUL, S_ACC, S_WR, S_DIV_INIT, S_DIV, S_LD_SAT, S_FIN
  } state_e;

  state_e     state_q;
  logic       ldot_q;
  logic [1:0] idx_q;
  logic [5:0] step_q;
  logic [5:0] cnt_q;
  logic       first_q;
  logic       out_valid_q;
  uop_t       cur;
  logic       out_free;

  function automatic uop_t mk(input asrc_e as, input logic [3:0] ai, input bsrc_e bs,
                              input logic [3:0] bi, input accm_e am, input dst_e ds,
                              input logic [3:0] di);
    uop_t u;
    u.asrc = as; u.aidx = ai; u.bsrc = bs; u.bidx = bi;
    u.accm = am; u.dst = ds; u.didx = di;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [5:0] s);
    uop_t u;
    unique case (s)
      // omega = los x ldot
      6'd0:  u = mk(SA_LD, 4'd2, SB_LOS, 4'd1, ACC_SET, DST_NONE, 4'd0);
      6'd1:  u = mk(SA_LD, 4'd1, SB_LOS, 4'd2, ACC_SUB, DST_OM, 4'd0);
      6'd2:  u = mk(SA_LD, 4'd0, SB_LOS, 4'd2, ACC_SET, DST_NONE, 4'd0);
      6'd3:  u = mk(SA_LD, 4'd2, SB_LOS, 4'd0, ACC_SUB, DST_OM, 4'd1);
      6'd4:  u = mk(SA_LD, 4'd1, SB_LOS, 4'd0, ACC_SET, DST_NONE, 4'd0);
      6'd5:  u = mk(SA_LD, 4'd0, SB_LOS, 4'd1, ACC_SUB, DST_OM, 4'd2);
      // c = omega x los
      6'd6:  u = mk(SA_OM, 4'd1, SB_LOS, 4'd2, ACC_SET, DST_NONE, 4'd0);
      6'd7:  u = mk(SA_OM, 4'd2, SB_LOS, 4'd1, ACC_SUB, DST_C, 4'd0);
      6'd8:  u = mk(SA_OM, 4'd2, SB_LOS, 4'd0, ACC_SET, DST_NONE, 4'd0);
      6'd9:  u = mk(SA_OM, 4'd0, SB_LOS, 4'd2, ACC_SUB, DST_C, 4'd1);
      6'd10: u = mk(SA_OM, 4'd0, SB_LOS, 4'd1, ACC_SET, DST_NONE, 4'd0);
      6'd11: u = mk(SA_OM, 4'd1, SB_LOS, 4'd0, ACC_SUB, DST_C, 4'd2);
      // gain
      6'd12: u = mk(SA_C, 4'd0, SB_GAIN, 4'd0, ACC_SET, DST_ACCEL, 4'd0);
      6'd13: u = mk(SA_C, 4'd1, SB_GAIN, 4'd0, ACC_SET, DST_ACCEL, 4'd1);
      6'd14: u = mk(SA_C, 4'd2, SB_GAIN, 4'd0, ACC_SET, DST_ACCEL, 4'd2);
      // quaternion products ww xx yy zz xy xz yz wx wy wz
      6'd15: u = mk(SA_QUAT, 4'd0, SB_QUAT, 4'd0, ACC_SET, DST_PROD, 4'd0);
      6'd16: u = mk(SA_QUAT, 4'd1, SB_QUAT, 4'd1, ACC_SET, DST_PROD, 4'd1);
      6'd17: u = mk(SA_QUAT, 4'd2, SB_QUAT, 4'd2, ACC_SET, DST_PROD, 4'd2);
      6'd18: u = mk(SA_QUAT, 4'd3, SB_QUAT, 4'd3, ACC_SET, DST_PROD, 4'd3);
      6'd19: u = mk(SA_QUAT, 4'd1, SB_QUAT, 4'd2, ACC_SET, DST_PROD, 4'd4);
      6'd20: u = mk(SA_QUAT, 4'd1, SB_QUAT, 4'd3, ACC_SET, DST_PROD, 4'd5);
      6'd21: u = mk(SA_QUAT, 4'd2, SB_QUAT, 4'd3, ACC_SET, DST_PROD, 4'd6);
      6'd22: u = mk(SA_QUAT, 4'd0, SB_QUAT, 4'd1, ACC_SET, DST_PROD, 4'd7);
      6'd23: u = mk(SA_QUAT, 4'd0, SB_QUAT, 4'd2, ACC_SET, DST_PROD, 4'd8);
      6'd24: u = mk(SA_QUAT, 4'd0, SB_QUAT, 4'd3, ACC_SET, DST_PROD, 4'd9);
      // body-frame rotation
      6'd25: u = mk(SA_ACCEL, 4'd0, SB_ROT, 4'd0, ACC_SET, DST_NONE, 4'd0);
      6'd26: u = mk(SA_ACCEL, 4'd1, SB_ROT, 4'd1, ACC_ADD, DST_NONE, 4'd0);
      6'd27: u = mk(SA_ACCEL, 4'd2, SB_ROT, 4'd2, ACC_ADD, DST_RES, 4'd0);
      6'd28: u = mk(SA_ACCEL, 4'd0, SB_ROT, 4'd3, ACC_SET, DST_NONE, 4'd0);
      6'd29: u = mk(SA_ACCEL, 4'd1, SB_ROT, 4'd4, ACC_ADD, DST_NONE, 4'd0);
      6'd30: u = mk(SA_ACCEL, 4'd2, SB_ROT, 4'd5, ACC_ADD, DST_RES, 4'd1);
      6'd31: u = mk(SA_ACCEL, 4'd0, SB_ROT, 4'd6, ACC_SET, DST_NONE, 4'd0);
      6'd32: u = mk(SA_ACCEL, 4'd1, SB_ROT, 4'd7, ACC_ADD, DST_NONE, 4'd0);
      6'd33: u = mk(SA_ACCEL, 4'd2, SB_ROT, 4'd8, ACC_ADD, DST_RES, 4'd2);
      default: u = mk(SA_LD, 4'd0, SB_LOS, 4'd0, ACC_SET, DST_NONE, 4'd0);
    endcase
    return u;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cur = ldot_q ? mk(SA_DMAG, {2'b00, idx_q}, SB_SCALE, 4'd0, ACC_SET, DST_NONE, 4'd0)
                 : uop_at(step_q);
    ctl_o.uop = cur;
    ctl_o.idx = idx_q;
    unique case (state_q)
      S_IDLE:     ctl_o.cmd = in_valid_i ? CMD_LOAD : CMD_NONE;
      S_OPND:     ctl_o.cmd = CMD_OPND;
      S_MUL:      ctl_o.cmd = CMD_MUL;
      S_ACC:      ctl_o.cmd = CMD_ACC;
      S_WR:       ctl_o.cmd = CMD_WR;
      S_DIV_INIT: ctl_o.cmd = CMD_DIV_INIT;
      S_DIV:      ctl_o.cmd = CMD_DIV_STEP;
      S_LD_SAT:   ctl_o.cmd = CMD_LD_SAT;
      S_FIN:      ctl_o.cmd = out_free ? CMD_OUT : CMD_NONE;
      default:    ctl_o.cmd = CMD_NONE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ldot_q      <= 1'b0;
      idx_q       <= 2'd0;
      step_q      <= 6'd0;
      cnt_q       <= 6'd0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            first_q <= 1'b0;
            ldot_q  <= !first_q;  // first tick has zero ldot
            idx_q   <= 2'd0;
            step_q  <= 6'd0;
            state_q <= S_OPND;
          end
        end
        S_OPND: state_q <= S_MUL;
        S_MUL:  state_q <= S_ACC;
        S_ACC: begin
          if (ldot_q) begin
            state_q <= S_DIV_INIT;
          end else if (cur.dst != DST_NONE) begin
            state_q <= S_WR;
          end else if (step_q == LAST_STEP) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= step_q + 6'd1;
            state_q <= S_OPND;
          end
        end
        S_WR: begin
          if (step_q == LAST_STEP) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= step_q + 6'd1;
            state_q <= S_OPND;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= 6'(NUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            state_q <= S_LD_SAT;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_LD_SAT: begin
          if (idx_q == 2'd2) begin
            ldot_q <= 1'b0;
            step_q <= 6'd0;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
          state_q <= S_OPND;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST_STEP) else $error("step past end of program");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3) else $error("ldot component index out of range");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN) else $error("result without finish");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_OPND)
    else $error("accepted beat did not start work");

endmodule
`default_nettype wire

>>> hdl/pgac_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_dpath
// Datapath: shared multiplier and accumulator, radix-2 ldot divider, result regs.
// ----------------------------------------------------------------------------
module pgac_dpath
  import pgac_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  ctl_t               ctl_i,
  input  wire  logic               cfg_we_i,
  input  wire  logic        [15:0] cfg_wdata_i,
  input  wire  logic signed [15:0] los_x_i,
  input  wire  logic signed [15:0] los_y_i,
  input  wire  logic signed [15:0] los_z_i,
  input  wire  logic signed [15:0] att_w_i,
  input  wire  logic signed [15:0] att_x_i,
  input  wire  logic signed [15:0] att_y_i,
  input  wire  logic signed [15:0] att_z_i,
  input  wire  logic        [19:0] dt_us_i,
  output logic signed [31:0]       acc_x_o,
  output logic signed [31:0]       acc_y_o,
  output logic signed [31:0]       acc_z_o,
  output logic                     saturated_o
);

  logic        [15:0] gain_q;
  logic signed [15:0] prev_q [3];
  logic signed [15:0] l_q    [3];
  logic signed [15:0] q_q    [4];
  logic signed [16:0] d_q    [3];
  logic        [19:0] dt_q;
  logic signed [31:0] ld_q   [3];
  logic signed [34:0] om_q   [3];
  logic signed [36:0] c_q    [3];
  logic signed [31:0] ac_q   [3];
  logic signed [31:0] p_q    [10];
  logic signed [31:0] res_q  [3];
  logic signed [36:0] opa_q;
  logic signed [29:0] opb_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic        [NUM_W-1:0] num_q;
  logic        [20:0] rem_q;
  logic               flag_q;

  logic signed [15:0] los_in [3];
  logic        [16:0] dmag;
  logic signed [36:0] a_mux;
  logic signed [29:0] b_mux;
  logic signed [33:0] r_raw;
  logic signed [29:0] r_rnd;
  logic signed [66:0] prod_full;
  logic signed [63:0] rnd_cross, rnd_gain, rnd_out, ld_full;
  logic        [20:0] rem_sh;
  logic               ge;

  assign los_in[0] = los_x_i;
  assign los_in[1] = los_y_i;
  assign los_in[2] = los_z_i;

  always_comb begin
    logic signed [16:0] dsel;
    dsel = d_q[ctl_i.uop.aidx[1:0]];
    dmag = dsel[16] ? 17'(-dsel) : 17'(dsel);
  end

  // rotation matrix of conj(q) from the stored products
  always_comb begin
    unique case (ctl_i.uop.bidx)
      4'd0: r_raw = 34'(p_q[0]) + 34'(p_q[1]) - 34'(p_q[2]) - 34'(p_q[3]);
      4'd1: r_raw = (34'(p_q[4]) + 34'(p_q[9])) <<< 1;
      4'd2: r_raw = (34'(p_q[5]) - 34'(p_q[8])) <<< 1;
      4'd3: r_raw = (34'(p_q[4]) - 34'(p_q[9])) <<< 1;
      4'd4: r_raw = 34'(p_q[0]) - 34'(p_q[1]) + 34'(p_q[2]) - 34'(p_q[3]);
      4'd5: r_raw = (34'(p_q[6]) + 34'(p_q[7])) <<< 1;
      4'd6: r_raw = (34'(p_q[5]) + 34'(p_q[8])) <<< 1;
      4'd7: r_raw = (34'(p_q[6]) - 34'(p_q[7])) <<< 1;
      4'd8: r_raw = 34'(p_q[0]) - 34'(p_q[1]) - 34'(p_q[2]) + 34'(p_q[3]);
      default: r_raw = '0;
    endcase
    r_rnd = 30'(rnd_shr(64'(r_raw), SH_ROT));
  end

  always_comb begin
    unique case (ctl_i.uop.asrc)
      SA_LD:    a_mux = 37'(ld_q[ctl_i.uop.aidx[1:0]]);
      SA_OM:    a_mux = 37'(om_q[ctl_i.uop.aidx[1:0]]);
      SA_C:     a_mux = c_q[ctl_i.uop.aidx[1:0]];
      SA_ACCEL: a_mux = 37'(ac_q[ctl_i.uop.aidx[1:0]]);
      SA_QUAT:  a_mux = 37'(q_q[ctl_i.uop.aidx[1:0]]);
      SA_DMAG:  a_mux = $signed({20'b0, dmag});
      default:  a_mux = '0;
    endcase
    unique case (ctl_i.uop.bsrc)
      SB_LOS:   b_mux = 30'(l_q[ctl_i.uop.bidx[1:0]]);
      SB_GAIN:  b_mux = $signed({14'b0, gain_q});
      SB_ROT:   b_mux = r_rnd;
      SB_QUAT:  b_mux = 30'(q_q[ctl_i.uop.bidx[1:0]]);
      SB_SCALE: b_mux = $signed(LDOT_SCALE);
      default:  b_mux = '0;
    endcase
  end

  assign prod_full = opa_q * opb_q;
  assign rnd_cross = rnd_shr(acc_q, SH_CROSS);
  assign rnd_gain  = rnd_shr(acc_q, SH_GAIN);
  assign rnd_out   = rnd_shr(acc_q, SH_OUT);
  assign ld_full   = d_q[ctl_i.idx][16] ? -$signed({26'b0, num_q})
                                        : $signed({26'b0, num_q});
  assign rem_sh    = {rem_q[19:0], num_q[NUM_W-1]};
  assign ge        = (rem_sh >= {1'b0, dt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (ctl_i.cmd == CMD_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          prev_q[i] <= los_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      CMD_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          l_q[i]  <= los_in[i];
          d_q[i]  <= 17'(los_in[i]) - 17'(prev_q[i]);
          ld_q[i] <= '0;
        end
        q_q[0] <= att_w_i;
        q_q[1] <= att_x_i;
        q_q[2] <= att_y_i;
        q_q[3] <= att_z_i;
        dt_q   <= (dt_us_i == 20'd0) ? 20'd1 : dt_us_i;
        flag_q <= 1'b0;
      end
      CMD_OPND: begin
        opa_q <= a_mux;
        opb_q <= b_mux;
      end
      CMD_MUL: prod_q <= prod_full[63:0];
      CMD_ACC: begin
        unique case (ctl_i.uop.accm)
          ACC_SET: acc_q <= prod_q;
          ACC_ADD: acc_q <= acc_q + prod_q;
          ACC_SUB: acc_q <= acc_q - prod_q;
          default: acc_q <= prod_q;
        endcase
      end
      CMD_WR: begin
        unique case (ctl_i.uop.dst)
          DST_OM: om_q[ctl_i.uop.didx[1:0]] <= rnd_cross[34:0];
          DST_C:  c_q[ctl_i.uop.didx[1:0]]  <= rnd_cross[36:0];
          DST_ACCEL: begin
            ac_q[ctl_i.uop.didx[1:0]] <= sat32(rnd_gain);
            flag_q <= flag_q | ovf32(rnd_gain);
          end
          DST_PROD: p_q[ctl_i.uop.didx] <= acc_q[31:0];
          DST_RES: begin
            res_q[ctl_i.uop.didx[1:0]] <= sat32(rnd_out);
            flag_q <= flag_q | ovf32(rnd_out);
          end
          default: ;
        endcase
      end
      CMD_DIV_INIT: begin
        // dividend is |diff| * scale plus half dt for rounding
        num_q <= acc_q[NUM_W-1:0] + NUM_W'(dt_q[19:1]);
        rem_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= ge ? (rem_sh - {1'b0, dt_q}) : rem_sh;
        num_q <= {num_q[NUM_W-2:0], ge};
      end
      CMD_LD_SAT: begin
        ld_q[ctl_i.idx] <= sat32(ld_full);
        flag_q <= flag_q | ovf32(ld_full);
      end
      CMD_OUT: begin
        acc_x_o     <= res_q[0];
        acc_y_o     <= res_q[1];
        acc_z_o     <= res_q[2];
        saturated_o <= flag_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_pn_guidance_accel_command.sv
// ----------------------------------------------------------------------------
// tb_pn_guidance_accel_command
// Drives guidance ticks through the block under several nav gain settings,
// predicts each acceleration command in fixed point and checks every beat.
// ----------------------------------------------------------------------------
module tb_pn_guidance_accel_command;
  import pgac_pkg::*;

  typedef struct {
    logic signed [15:0] lx, ly, lz, qw, qx, qy, qz;
    logic        [19:0] dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] ax, ay, az;
    logic               sat;
  } accel_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic        [15:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] los_x_i = '0, los_y_i = '0, los_z_i = '0;
  logic signed [15:0] att_w_i = '0, att_x_i = '0, att_y_i = '0, att_z_i = '0;
  logic        [19:0] dt_us_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] acc_x_o, acc_y_o, acc_z_o;
  logic               saturated_o;

  pn_guidance_accel_command dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .los_x_i(los_x_i), .los_y_i(los_y_i), .los_z_i(los_z_i),
    .att_w_i(att_w_i), .att_x_i(att_x_i), .att_y_i(att_y_i), .att_z_i(att_z_i),
    .dt_us_i(dt_us_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .acc_x_o(acc_x_o), .acc_y_o(acc_y_o), .acc_z_o(acc_z_o), .saturated_o(saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tick_t      pending_ticks[$];
  accel_cmd_t expected_cmds[$];
  int         errors = 0;
  int         n_taken = 0;
  bit         beat_taken = 0;

  // predictor state
  logic [15:0]        gain_q = GAIN_RESET;
  logic signed [15:0] last_los[3] = '{0, 0, 0};
  bit                 first_q = 1;

  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint v, ref bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic accel_cmd_t predict_command(tick_t t);
    longint L[3], ld[3], om[3], c[3], a[3], res[3], R[3][3];
    longint pw, px, py, pz, d, acc;
    longint unsigned q, dtv;
    bit f;
    accel_cmd_t r;
    f = 0;
    L[0] = t.lx; L[1] = t.ly; L[2] = t.lz;
    ld = '{0, 0, 0};
    dtv = (t.dt == 0) ? 1 : t.dt;
    if (!first_q) begin
      for (int i = 0; i < 3; i++) begin
        d = L[i] - longint'(last_los[i]);
        q = ((d < 0 ? longint'(-d) : d) * 64'd4000000 + dtv / 2) / dtv;
        ld[i] = clip32(d < 0 ? -longint'(q) : longint'(q), f);
      end
    end
    first_q = 0;
    for (int i = 0; i < 3; i++) last_los[i] = 16'(L[i]);
    om[0] = round_shift(L[1] * ld[2] - L[2] * ld[1], 14);
    om[1] = round_shift(L[2] * ld[0] - L[0] * ld[2], 14);
    om[2] = round_shift(L[0] * ld[1] - L[1] * ld[0], 14);
    c[0] = round_shift(om[1] * L[2] - om[2] * L[1], 14);
    c[1] = round_shift(om[2] * L[0] - om[0] * L[2], 14);
    c[2] = round_shift(om[0] * L[1] - om[1] * L[0], 14);
    for (int i = 0; i < 3; i++) a[i] = clip32(round_shift(c[i] * longint'(gain_q), 8), f);
    // conjugate of the attitude
    pw = t.qw; px = -longint'(t.qx); py = -longint'(t.qy); pz = -longint'(t.qz);
    R[0][0] = pw * pw + px * px - py * py - pz * pz;
    R[0][1] = 2 * (px * py - pw * pz);
    R[0][2] = 2 * (px * pz + pw * py);
    R[1][0] = 2 * (px * py + pw * pz);
    R[1][1] = pw * pw - px * px + py * py - pz * pz;
    R[1][2] = 2 * (py * pz - pw * px);
    R[2][0] = 2 * (px * pz - pw * py);
    R[2][1] = 2 * (py * pz + pw * px);
    R[2][2] = pw * pw - px * px - py * py + pz * pz;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += round_shift(R[i][j], 4) * a[j];
      res[i] = clip32(round_shift(acc, 24), f);
    end
    r.ax = 32'(res[0]); r.ay = 32'(res[1]); r.az = 32'(res[2]); r.sat = f;
    return r;
  endfunction

  // accepted input beats feed the predictor
  always @(posedge clk_i) begin
    tick_t t;
    beat_taken = in_valid_i && !in_stall_o;
    if (beat_taken) begin
      t.lx = los_x_i; t.ly = los_y_i; t.lz = los_z_i;
      t.qw = att_w_i; t.qx = att_x_i; t.qy = att_y_i; t.qz = att_z_i;
      t.dt = dt_us_i;
      expected_cmds.push_back(predict_command(t));
      n_taken++;
    end
  end

  // driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    tick_t t;
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        t = pending_ticks.pop_front();
        los_x_i <= t.lx; los_y_i <= t.ly; los_z_i <= t.lz;
        att_w_i <= t.qw; att_x_i <= t.qx; att_y_i <= t.qy; att_z_i <= t.qz;
        dt_us_i <= t.dt;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back up the input
  int  hold_left = 0;
  bit  held_once = 0;
  int  pat_cnt = 0;
  bit  pat_busy = 0;
  always @(negedge clk_i) begin
    bit s;
    if (hold_left > 0) begin
      hold_left--;
      s = 1;
    end else if (!held_once && n_taken >= 400) begin
      held_once = 1;
      hold_left = 3000;
      s = 1;
    end else begin
      pat_cnt++;
      if (pat_cnt % 512 == 0) pat_busy = bit'($urandom_range(0, 1));
      s = pat_busy && ($urandom_range(0, 3) != 0);
    end
    out_stall_i <= s;
  end

  // result check
  always @(posedge clk_i) begin
    accel_cmd_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected beat acc=%0d,%0d,%0d sat=%0b", $time,
                 acc_x_o, acc_y_o, acc_z_o, saturated_o);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (acc_x_o !== e.ax) begin
          $display("%0t: acc_x expected %0d actual %0d", $time, e.ax, acc_x_o);
          errors++;
        end
        if (acc_y_o !== e.ay) begin
          $display("%0t: acc_y expected %0d actual %0d", $time, e.ay, acc_y_o);
          errors++;
        end
        if (acc_z_o !== e.az) begin
          $display("%0t: acc_z expected %0d actual %0d", $time, e.az, acc_z_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus
  logic signed [15:0] walk_los[3] = '{16384, 0, 0};

  function automatic tick_t make_tick(logic signed [15:0] lx, logic signed [15:0] ly,
                                      logic signed [15:0] lz, logic signed [15:0] qw,
                                      logic signed [15:0] qx, logic signed [15:0] qy,
                                      logic signed [15:0] qz, logic [19:0] dt);
    tick_t t;
    t.lx = lx; t.ly = ly; t.lz = lz; t.qw = qw; t.qx = qx; t.qy = qy; t.qz = qz; t.dt = dt;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // slowly turning line of sight with a near-unit attitude
      for (int i = 0; i < 3; i++)
        walk_los[i] = walk_los[i] + $signed(16'($urandom_range(0, 400)) - 16'd200);
      t.lx = walk_los[0]; t.ly = walk_los[1]; t.lz = walk_los[2];
      t.qw = 16'(16384 - $urandom_range(0, 2000));
      t.qx = 16'($urandom_range(0, 4000) - 2000);
      t.qy = 16'($urandom_range(0, 4000) - 2000);
      t.qz = 16'($urandom_range(0, 4000) - 2000);
      t.dt = 20'((k == 0) ? $urandom_range(0, 3) : $urandom_range(1000, 200000));
    end else begin
      t.lx = 16'($urandom); t.ly = 16'($urandom); t.lz = 16'($urandom);
      t.qw = 16'($urandom); t.qx = 16'($urandom); t.qy = 16'($urandom);
      t.qz = 16'($urandom);
      t.dt = 20'($urandom);
    end
    return t;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_cmds.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    gain_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  logic [15:0] gains[6] = '{16'd0, 16'd65535, 16'd1, 16'd256, 16'd5120, 16'd0};

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first tick, then zero dt, extremes and odd quaternions
    pending_ticks.push_back(make_tick(16384, 0, 0, 16384, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(0, 16384, 0, 16384, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(0, 0, 16384, 16384, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(32767, -32768, 32767, 32767, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(-32768, 32767, -32768, -32768, -32768, -32768, -32768, 0));
    pending_ticks.push_back(make_tick(32767, 32767, 32767, 32767, 32767, 32767, 32767, 20'hFFFFF));
    pending_ticks.push_back(make_tick(-32768, -32768, -32768, 0, 0, 0, 0, 20'hFFFFF));
    pending_ticks.push_back(make_tick(11585, 11585, 0, 11585, 0, 0, 11585, 100000));
    pending_ticks.push_back(make_tick(11585, 11000, 500, 11585, 11585, 0, 0, 100000));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 16384, 0, 50000));
    pending_ticks.push_back(make_tick(16384, 100, -100, 100, 20000, -300, 8000, 2));
    pending_ticks.push_back(make_tick(16384, 100, -100, 100, 20000, -300, 8000, 7));
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_gain(p < 6 ? gains[p] : 16'($urandom));
      for (int n = 0; n < 155; n++) pending_ticks.push_back(random_tick());
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
